// ===== src/tls13_hello_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// tls13 hello parser assertion macros
// shared concurrent check forms, clocked on i_clk, held off while in reset
// ----------------------------------------------------------------------------
`ifndef TLS13_HELLO_PARSER_UNIT_ASSERT_SVH
`define TLS13_HELLO_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define TLSH_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlsh check failed");

// next-cycle implication
`define TLSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlsh check failed");

`endif

// ===== src/tlsh_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsh_pkg
// types and fixed constants of the tls 1.3 hello parser
// ----------------------------------------------------------------------------
package tlsh_pkg;

    localparam logic [5:0]  RANDOM_BYTES = 6'd32;
    localparam logic [24:0] OFFSET_MAX   = 25'h1FFFFFF;
    localparam int          FIFO_DEPTH   = 4;
    localparam int          FIFO_AW      = 2;

    // handshake type bytes
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [7:0]  HS_SERVER_HELLO = 8'd2;

    typedef logic [FIFO_AW:0] t_count;

    typedef enum logic [4:0] {
        PH_TYPE, PH_BLEN, PH_VER, PH_RAND, PH_SIDLEN, PH_SID, PH_SSUITE, PH_SCOMP,
        PH_CSLEN, PH_CS, PH_COMPLEN, PH_COMP, PH_EXTLEN, PH_ETYPE, PH_ELEN,
        PH_EDATA, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        K_VERSION, K_RANDOM, K_SESSION, K_SUITE, K_EXT, K_ACCEPT, K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  value;
        logic [5:0]   index;
        logic [15:0]  len;
        logic [24:0]  off;
        logic         last;
    } t_result;

    typedef struct packed {
        logic field_v;
        logic verdict_v;
    } t_push_ctl;

endpackage

// ===== src/tlsh_core.sv =====
// ----------------------------------------------------------------------------
// tlsh_core
// per-byte parse state and result generation, one byte per accepted beat
// ----------------------------------------------------------------------------
`include "tls13_hello_parser_unit_assert.svh"

module tlsh_core #(
    parameter int MAX_SUITES     = 64,
    parameter int MAX_EXTENSIONS = 32,
    parameter int SESSION_ID_MAX = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_accept,
    input  logic [7:0]         i_msg_byte,
    input  logic               i_last_byte,
    output tlsh_pkg::t_push_ctl o_ctl,
    output tlsh_pkg::t_result  o_field,
    output tlsh_pkg::t_result  o_verdict
);
    import tlsh_pkg::*;

    localparam int SW = $clog2(MAX_SUITES + 1);
    localparam int EW = $clog2(MAX_EXTENSIONS + 1);
    localparam logic [7:0]    SID_MAX_B = 8'(SESSION_ID_MAX);
    localparam logic [SW-1:0] SUITE_LIM = SW'(MAX_SUITES);
    localparam logic [EW-1:0] EXT_LIM   = EW'(MAX_EXTENSIONS);

    logic          r_server;
    t_phase        r_phase,  n_phase;
    logic [23:0]   r_body,   n_body;
    logic [15:0]   r_vec,    n_vec;
    logic [15:0]   r_inner,  n_inner;
    logic [23:0]   r_shift,  n_shift;
    logic [5:0]    r_cnt,    n_cnt;
    logic [SW-1:0] r_suite,  n_suite;
    logic [EW-1:0] r_ext,    n_ext;
    logic [24:0]   r_off,    n_off;
    logic          r_failed, n_failed;

    logic [23:0] g_shift;
    logic [5:0]  g_cnt;
    logic [15:0] g_val;
    logic        in_body, in_ext, stop, ok;
    t_result     fld;
    logic        fld_v;

    assign g_shift = {r_shift[15:0], i_msg_byte};
    assign g_cnt   = r_cnt + 6'd1;
    assign g_val   = g_shift[15:0];
    assign in_body = (r_phase != PH_TYPE) && (r_phase != PH_BLEN);
    assign in_ext  = (r_phase == PH_ETYPE) || (r_phase == PH_ELEN) || (r_phase == PH_EDATA);

    always_comb begin
        n_phase  = r_phase;
        n_body   = r_body;
        n_vec    = r_vec;
        n_inner  = r_inner;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_suite  = r_suite;
        n_ext    = r_ext;
        n_off    = r_off;
        n_failed = r_failed;
        fld      = '0;
        fld_v    = 1'b0;
        stop     = 1'b0;
        ok       = 1'b0;

        if (!r_failed) begin
            // body and extension-list budget checks come before the field logic
            if (in_body) begin
                if (r_phase == PH_DONE || r_body == 24'd0) begin
                    n_failed = 1'b1;
                    stop     = 1'b1;
                end else begin
                    n_body = r_body - 24'd1;
                end
            end
            if (!stop && in_ext) begin
                if (r_vec == 16'd0) begin
                    n_failed = 1'b1;
                    stop     = 1'b1;
                end else begin
                    n_vec = r_vec - 16'd1;
                end
            end
            if (!stop) begin
                case (r_phase)
                    PH_TYPE: begin
                        if (i_msg_byte != (r_server ? HS_SERVER_HELLO : HS_CLIENT_HELLO))
                            n_failed = 1'b1;
                        n_phase = PH_BLEN;
                    end
                    PH_BLEN: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd3) begin
                            n_body  = g_shift;
                            n_shift = '0;
                            n_cnt   = '0;
                            n_phase = PH_VER;
                        end
                    end
                    PH_VER: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift   = '0;
                            n_cnt     = '0;
                            n_phase   = PH_RAND;
                            fld_v     = 1'b1;
                            fld.kind  = K_VERSION;
                            fld.value = g_val;
                        end
                    end
                    PH_RAND: begin
                        fld_v     = 1'b1;
                        fld.kind  = K_RANDOM;
                        fld.value = {8'd0, i_msg_byte};
                        fld.index = r_cnt;
                        n_cnt     = g_cnt;
                        if (g_cnt >= RANDOM_BYTES) begin
                            n_cnt   = '0;
                            n_phase = PH_SIDLEN;
                        end
                    end
                    PH_SIDLEN: begin
                        if (i_msg_byte > SID_MAX_B || {16'd0, i_msg_byte} > n_body) begin
                            n_failed = 1'b1;
                        end else begin
                            n_vec = {8'd0, i_msg_byte};
                            n_cnt = '0;
                            if (i_msg_byte == 8'd0) begin
                                n_phase = r_server ? PH_SSUITE : PH_CSLEN;
                            end else begin
                                n_phase = PH_SID;
                            end
                        end
                    end
                    PH_SID: begin
                        fld_v     = 1'b1;
                        fld.kind  = K_SESSION;
                        fld.value = {8'd0, i_msg_byte};
                        fld.index = r_cnt;
                        n_cnt     = g_cnt;
                        n_vec     = r_vec - 16'd1;
                        if (n_vec == 16'd0) begin
                            n_cnt   = '0;
                            n_phase = r_server ? PH_SSUITE : PH_CSLEN;
                        end
                    end
                    PH_SSUITE: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift   = '0;
                            n_cnt     = '0;
                            n_suite   = SW'(1);
                            n_phase   = PH_SCOMP;
                            fld_v     = 1'b1;
                            fld.kind  = K_SUITE;
                            fld.value = g_val;
                        end
                    end
                    PH_SCOMP: begin
                        if (i_msg_byte != 8'd0) n_failed = 1'b1;
                        else                    n_phase  = PH_EXTLEN;
                    end
                    PH_CSLEN: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            if ({8'd0, g_val} > n_body) begin
                                n_failed = 1'b1;
                            end else begin
                                n_vec   = g_val;
                                n_suite = '0;
                                n_phase = (g_val == 16'd0) ? PH_COMPLEN : PH_CS;
                            end
                        end
                    end
                    PH_CS: begin
                        n_vec   = r_vec - 16'd1;
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            if (r_suite < SUITE_LIM) begin
                                fld_v     = 1'b1;
                                fld.kind  = K_SUITE;
                                fld.value = g_val;
                                fld.index = 6'(r_suite);
                                n_suite   = SW'(r_suite + 1'b1);
                            end
                        end
                        if (n_vec == 16'd0) begin
                            // odd list length leaves half a suite behind
                            if (n_cnt != 6'd0) begin
                                n_failed = 1'b1;
                                fld_v    = 1'b0;
                            end else begin
                                n_phase = PH_COMPLEN;
                            end
                        end
                    end
                    PH_COMPLEN: begin
                        if (i_msg_byte != 8'd1) n_failed = 1'b1;
                        else                    n_phase  = PH_COMP;
                    end
                    PH_COMP: begin
                        if (i_msg_byte != 8'd0) n_failed = 1'b1;
                        else                    n_phase  = PH_EXTLEN;
                    end
                    PH_EXTLEN: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            if ({8'd0, g_val} > n_body) begin
                                n_failed = 1'b1;
                            end else begin
                                n_vec   = g_val;
                                n_ext   = '0;
                                n_phase = (g_val == 16'd0) ? PH_DONE : PH_ETYPE;
                            end
                        end
                    end
                    PH_ETYPE: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_inner = g_val;
                            n_shift = '0;
                            n_cnt   = '0;
                            n_phase = PH_ELEN;
                        end
                    end
                    PH_ELEN: begin
                        n_shift = g_shift;
                        n_cnt   = g_cnt;
                        if (g_cnt >= 6'd2) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            if (g_val > n_vec || r_ext >= EXT_LIM) begin
                                n_failed = 1'b1;
                            end else begin
                                fld_v     = 1'b1;
                                fld.kind  = K_EXT;
                                fld.value = r_inner;
                                fld.index = 6'(r_ext);
                                fld.len   = g_val;
                                fld.off   = r_off + 25'd1;
                                n_ext     = EW'(r_ext + 1'b1);
                                n_inner   = g_val;
                                if (g_val == 16'd0) begin
                                    n_phase = (n_vec == 16'd0) ? PH_DONE : PH_ETYPE;
                                end else begin
                                    n_phase = PH_EDATA;
                                end
                            end
                        end
                    end
                    PH_EDATA: begin
                        if (r_inner != 16'd0) n_inner = r_inner - 16'd1;
                        if (n_inner == 16'd0) begin
                            n_phase = (n_vec == 16'd0) ? PH_DONE : PH_ETYPE;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end
        end

        if (i_last_byte) begin
            ok       = !n_failed && (n_phase == PH_DONE) && (n_body == 24'd0);
            n_phase  = PH_TYPE;
            n_body   = '0;
            n_vec    = '0;
            n_inner  = '0;
            n_shift  = '0;
            n_cnt    = '0;
            n_suite  = '0;
            n_ext    = '0;
            n_off    = '0;
            n_failed = 1'b0;
        end else if (r_off != OFFSET_MAX) begin
            n_off = r_off + 25'd1;
        end
    end

    always_comb begin
        o_field           = fld;
        o_verdict         = '0;
        o_verdict.kind    = ok ? K_ACCEPT : K_REJECT;
        o_verdict.last    = 1'b1;
        o_ctl.field_v     = i_accept && fld_v;
        o_ctl.verdict_v   = i_accept && i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server <= 1'b0;
        end else if (i_cfg_we) begin
            r_server <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_body   <= '0;
            r_vec    <= '0;
            r_inner  <= '0;
            r_shift  <= '0;
            r_cnt    <= '0;
            r_suite  <= '0;
            r_ext    <= '0;
            r_off    <= '0;
            r_failed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_body   <= n_body;
            r_vec    <= n_vec;
            r_inner  <= n_inner;
            r_shift  <= n_shift;
            r_cnt    <= n_cnt;
            r_suite  <= n_suite;
            r_ext    <= n_ext;
            r_off    <= n_off;
            r_failed <= n_failed;
        end
    end

    `TLSH_ASSERT_NEXT(a_last_restarts, i_accept && i_last_byte, r_phase == PH_TYPE && !r_failed)
    `TLSH_ASSERT_HOLD(a_no_field_after_fail, o_ctl.field_v, !r_failed)

endmodule

// ===== src/tlsh_fifo.sv =====
// ----------------------------------------------------------------------------
// tlsh_fifo
// small result queue, takes up to two beats per cycle, drains one
// ----------------------------------------------------------------------------
`include "tls13_hello_parser_unit_assert.svh"

module tlsh_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlsh_pkg::t_push_ctl i_ctl,
    input  tlsh_pkg::t_result   i_field,
    input  tlsh_pkg::t_result   i_verdict,
    input  logic                i_pop,
    output logic                o_room2,
    output logic                o_valid,
    output tlsh_pkg::t_result   o_head
);
    import tlsh_pkg::*;

    localparam t_count DEPTH_C = t_count'(FIFO_DEPTH);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    t_count             r_count, n_count;
    t_count             push_n;

    assign push_n  = t_count'(i_ctl.field_v) + t_count'(i_ctl.verdict_v);
    assign n_count = r_count + push_n - t_count'(i_pop);
    assign o_room2 = r_count <= (DEPTH_C - t_count'(2));
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_ctl.field_v) begin
            r_mem[r_wr] <= i_field;
            if (i_ctl.verdict_v) r_mem[r_wr + 1'b1] <= i_verdict;
        end else if (i_ctl.verdict_v) begin
            r_mem[r_wr] <= i_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(push_n);
            r_rd    <= r_rd + FIFO_AW'(i_pop);
            r_count <= n_count;
        end
    end

    `TLSH_ASSERT_HOLD(a_count_range, 1'b1, r_count <= DEPTH_C)
    `TLSH_ASSERT_HOLD(a_no_overflow, push_n != '0, push_n <= DEPTH_C - r_count)

endmodule

// ===== src/tls13_hello_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tls13_hello_parser_unit
// streaming tls 1.3 clienthello / serverhello parser, one byte per beat
// ----------------------------------------------------------------------------
// Feed a handshake message one byte per input beat, with i_last_byte high on
// its final byte. A byte is taken every cycle while o_in_ready is high; its
// result beats (version, random bytes, session id bytes, suites, extension
// headers, and the accept/reject verdict on the final byte) appear on the
// output channel in order, from a registered queue. The parse state updates
// once per accepted byte. Most bytes give zero or one result beat; a final
// byte that also completes a field gives two, which the output side sends in
// turn. Results wait in a four-entry queue; the input is held off only while
// that queue cannot take two more beats, i.e. only when the consumer stalls.
// i_cfg_data selects serverhello (1) or clienthello (0) parsing and is written
// whenever i_cfg_we is high; change it only between messages.
// ----------------------------------------------------------------------------
module tls13_hello_parser_unit #(
    parameter int MAX_SUITES     = 64,
    parameter int MAX_EXTENSIONS = 32,
    parameter int SESSION_ID_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_field_value,
    output logic [5:0]  o_item_index,
    output logic [15:0] o_ext_length,
    output logic [24:0] o_ext_offset,
    output logic        o_last_result
);
    import tlsh_pkg::*;

    t_push_ctl push_ctl;
    t_result   res_field;
    t_result   res_verdict;
    t_result   head;
    logic      accept;
    logic      room2;

    // input beat taken only when the queue has space for a worst-case pair
    assign o_in_ready = room2;
    assign accept     = i_in_valid && room2;

    tlsh_core #(
        .MAX_SUITES     (MAX_SUITES),
        .MAX_EXTENSIONS (MAX_EXTENSIONS),
        .SESSION_ID_MAX (SESSION_ID_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_msg_byte  (i_msg_byte),
        .i_last_byte (i_last_byte),
        .o_ctl       (push_ctl),
        .o_field     (res_field),
        .o_verdict   (res_verdict)
    );

    // field beat is queued ahead of the verdict of the same byte
    tlsh_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (push_ctl),
        .i_field   (res_field),
        .i_verdict (res_verdict),
        .i_pop     (o_out_valid && i_out_ready),
        .o_room2   (room2),
        .o_valid   (o_out_valid),
        .o_head    (head)
    );

    assign o_result_kind = head.kind;
    assign o_field_value = head.value;
    assign o_item_index  = head.index;
    assign o_ext_length  = head.len;
    assign o_ext_offset  = head.off;
    assign o_last_result = head.last;

endmodule
